>>> sv/c16pd_pkg.sv
// Package for the CRC-16 packet deframer.
// Holds the phase and status types, framing constants and the CRC byte update.
// No dependencies.
package c16pd_pkg;

    // Largest number of parameter bytes a packet may carry
    localparam int MAX_PARAMS = 32;
    // Parameter store address width and parameter count width
    localparam int ADDR_W     = $clog2(MAX_PARAMS);
    localparam int CNT_W      = $clog2(MAX_PARAMS + 1);

    // Framing bytes
    localparam logic [7:0]  SYNC_BYTE = 8'hFF;
    localparam logic [7:0]  SYNC_LAST = 8'hFD;
    localparam logic [7:0]  ZERO_BYTE = 8'h00;
    localparam logic [15:0] CRC_POLY  = 16'h8005;
    localparam logic [15:0] CRC_INIT  = 16'h0000;

    // Smallest legal length: id, instruction and two CRC bytes
    localparam logic [7:0]  MIN_LEN = 8'd4;
    localparam logic [7:0]  MAX_LEN = 8'(MAX_PARAMS + 4);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_SYNC3,
        PH_LEN,
        PH_ZERO,
        PH_BODY,
        PH_EMIT
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_BAD_LEN = 2'd2
    } t_status;

    // One byte of CRC-16, MSB first, no reflection
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // CRC after the three sync bytes, settled at elaboration
    localparam logic [15:0] HDR_CRC =
        crc_feed(crc_feed(crc_feed(CRC_INIT, SYNC_BYTE), SYNC_BYTE), SYNC_LAST);

endpackage

>>> sv/crc16_packet_deframer.sv
// Top level of the CRC-16 packet deframer: header hunt, CRC check,
// parameter store and result emission. Depends on c16pd_pkg.
//
// Takes one received byte per beat and hunts for the header FF FF FD, a
// length byte and 00, then takes length payload bytes (id, instruction,
// parameters, CRC high then low). Bytes are accepted one per cycle; the
// input stalls only while a good packet's parameters are replayed from the
// parameter store, which delivers one result per cycle while the output is
// drained (one store read port, registered read data, pipelined against
// the output register), and for as long as a byte that ends a header or
// packet meets a full output register that is not being drained. A good
// packet gives one result per parameter, with the last one marked, or a
// single result if it has none; a CRC mismatch gives one crc_error result
// and an illegal length one bad_length result as soon as the header's 00
// byte arrives. Broken headers are dropped silently.
module crc16_packet_deframer
    import c16pd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] motor_id, [15:8] instruction,
                                        // [23:16] param_byte, [29:24] param_index,
                                        // [31:30] zero
    output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] has_param
    output logic        m_axis_tlast    // last
);

    // Control state
    t_phase             r_phase, n_phase;
    logic               r_out_valid, n_out_valid;
    logic               r_rd_pend, n_rd_pend;
    logic [CNT_W-1:0]   r_rd_idx, n_rd_idx;

    // Packet registers
    logic [7:0]         r_len, n_len;
    logic [7:0]         r_pos, n_pos;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         r_id, n_id;
    logic [7:0]         r_instr, n_instr;
    logic [7:0]         r_crc_hi, n_crc_hi;
    logic [CNT_W-1:0]   r_emit_n, n_emit_n;
    logic [5:0]         r_rd_pidx, n_rd_pidx;
    logic               r_rd_plast, n_rd_plast;

    // Output register
    logic [1:0]         r_status, n_status;
    logic [7:0]         r_out_id, n_out_id;
    logic [7:0]         r_out_instr, n_out_instr;
    logic [7:0]         r_out_param, n_out_param;
    logic [5:0]         r_out_pidx, n_out_pidx;
    logic               r_out_has, n_out_has;
    logic               r_out_last, n_out_last;

    // Parameter store
    logic [7:0]         mem [MAX_PARAMS];
    logic [7:0]         r_mem_q;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;

    logic               in_acc;
    logic               out_free;
    logic               may_emit;
    logic               ld;
    logic               issue;
    logic [8:0]         pos_p2;
    logic               len_bad;
    logic               crc_ok;
    logic [CNT_W-1:0]   nparams;
    logic [7:0]         b;

    assign b        = s_axis_tdata;
    assign out_free = !r_out_valid || m_axis_tready;
    assign pos_p2   = {1'b0, r_pos} + 9'd2;
    assign len_bad  = (r_len < MIN_LEN) || (r_len > MAX_LEN);
    assign crc_ok   = ({r_crc_hi, b} == r_crc);
    assign nparams  = CNT_W'(r_len - MIN_LEN);

    // A byte may raise a result when it closes a header or a packet
    assign may_emit = (r_phase == PH_ZERO) ||
                      ((r_phase == PH_BODY) && (pos_p2 > {1'b0, r_len}));

    assign s_axis_tready = (r_phase != PH_EMIT) && (!may_emit || out_free);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Replay: a pending read moves into the output register when it is free
    assign ld    = r_rd_pend && out_free;
    assign issue = (r_phase == PH_EMIT) && (r_rd_idx < r_emit_n) && (!r_rd_pend || ld);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_SYNC1: begin
                if (in_acc && b == SYNC_BYTE) n_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (in_acc) n_phase = (b == SYNC_BYTE) ? PH_SYNC3 : PH_SYNC1;
            end
            PH_SYNC3: begin
                if (in_acc) begin
                    if (b == SYNC_LAST)      n_phase = PH_LEN;
                    else if (b == SYNC_BYTE) n_phase = PH_SYNC3;
                    else                     n_phase = PH_SYNC1;
                end
            end
            PH_LEN: begin
                if (in_acc) n_phase = PH_ZERO;
            end
            PH_ZERO: begin
                if (in_acc) begin
                    if (b != ZERO_BYTE)  n_phase = (b == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
                    else if (len_bad)    n_phase = PH_SYNC1;
                    else                 n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (in_acc && pos_p2 > {1'b0, r_len}) begin
                    if (crc_ok && nparams != '0) n_phase = PH_EMIT;
                    else                         n_phase = PH_SYNC1;
                end
            end
            PH_EMIT: begin
                if (ld && r_rd_plast) n_phase = PH_SYNC1;
            end
            default: n_phase = PH_SYNC1;
        endcase
    end

    // Datapath and output register
    always_comb begin
        n_len       = r_len;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_id        = r_id;
        n_instr     = r_instr;
        n_crc_hi    = r_crc_hi;
        n_emit_n    = r_emit_n;
        n_rd_idx    = r_rd_idx;
        n_rd_pend   = r_rd_pend;
        n_rd_pidx   = r_rd_pidx;
        n_rd_plast  = r_rd_plast;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_status    = r_status;
        n_out_id    = r_out_id;
        n_out_instr = r_out_instr;
        n_out_param = r_out_param;
        n_out_pidx  = r_out_pidx;
        n_out_has   = r_out_has;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_waddr   = r_pos[ADDR_W-1:0] - ADDR_W'(2);

        unique case (r_phase)
            PH_SYNC3: begin
                // Sync bytes have a fixed CRC
                if (in_acc && b == SYNC_LAST) n_crc = HDR_CRC;
            end
            PH_LEN: begin
                if (in_acc) begin
                    n_len = b;
                    n_crc = crc_feed(r_crc, b);
                end
            end
            PH_ZERO: begin
                if (in_acc && b == ZERO_BYTE) begin
                    n_crc = crc_feed(r_crc, b);
                    n_pos = '0;
                    if (len_bad) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_BAD_LEN;
                        n_out_id    = '0;
                        n_out_instr = '0;
                        n_out_param = '0;
                        n_out_pidx  = '0;
                        n_out_has   = 1'b0;
                        n_out_last  = 1'b1;
                    end
                end
            end
            PH_BODY: begin
                if (in_acc) begin
                    n_pos = r_pos + 8'd1;
                    if (pos_p2 < {1'b0, r_len}) begin
                        n_crc = crc_feed(r_crc, b);
                        if (r_pos == 8'd0)      n_id    = b;
                        else if (r_pos == 8'd1) n_instr = b;
                        else                    mem_we  = 1'b1;
                    end else if (pos_p2 == {1'b0, r_len}) begin
                        n_crc_hi = b;
                    end else begin
                        // Low CRC byte closes the packet
                        n_pos    = '0;
                        n_rd_idx = '0;
                        n_emit_n = nparams;
                        if (!crc_ok || nparams == '0) begin
                            n_out_valid = 1'b1;
                            n_status    = crc_ok ? ST_OK : ST_CRC_ERR;
                            n_out_id    = r_id;
                            n_out_instr = r_instr;
                            n_out_param = '0;
                            n_out_pidx  = '0;
                            n_out_has   = 1'b0;
                            n_out_last  = 1'b1;
                        end
                    end
                end
            end
            PH_EMIT: begin
                if (ld) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_out_id    = r_id;
                    n_out_instr = r_instr;
                    n_out_param = r_mem_q;
                    n_out_pidx  = r_rd_pidx;
                    n_out_has   = 1'b1;
                    n_out_last  = r_rd_plast;
                    n_rd_pend   = 1'b0;
                end
                if (issue) begin
                    n_rd_pend  = 1'b1;
                    n_rd_pidx  = 6'(r_rd_idx);
                    n_rd_plast = (r_rd_idx + CNT_W'(1)) == r_emit_n;
                    n_rd_idx   = r_rd_idx + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Parameter store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= b;
        end
        if (issue) begin
            r_mem_q <= mem[r_rd_idx[ADDR_W-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC1;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_rd_idx    <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_rd_pend   <= n_rd_pend;
            r_rd_idx    <= n_rd_idx;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_crc       <= n_crc;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_id        <= n_id;
        r_instr     <= n_instr;
        r_crc_hi    <= n_crc_hi;
        r_emit_n    <= n_emit_n;
        r_rd_pidx   <= n_rd_pidx;
        r_rd_plast  <= n_rd_plast;
        r_status    <= n_status;
        r_out_id    <= n_out_id;
        r_out_instr <= n_out_instr;
        r_out_param <= n_out_param;
        r_out_pidx  <= n_out_pidx;
        r_out_has   <= n_out_has;
        r_out_last  <= n_out_last;
    end

    // Output beat
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_pidx, r_out_param, r_out_instr, r_out_id};
    assign m_axis_tuser  = {r_out_has, r_status};
    assign m_axis_tlast  = r_out_last;

endmodule

>>> bench/crc16_packet_deframer_tb.sv
// Testbench for crc16_packet_deframer: directed and random byte streams with
// an in-bench deframer model and a result scoreboard. Depends on c16pd_pkg.
`timescale 1ns / 100ps

module crc16_packet_deframer_tb
    import c16pd_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_REPORTS = 10;

    // One result beat, split into its fields
    typedef struct packed {
        t_status    status;
        logic [7:0] motor_id;
        logic [7:0] instr;
        logic [7:0] param;
        logic [5:0] index;
        logic       has_param;
        logic       last;
    } t_frame_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [7:0] motor_id, [15:8] instruction, [23:16] param_byte,
                                 // [29:24] param_index, [31:30] zero
    logic [2:0]  m_axis_tuser;   // [1:0] status, [2] has_param
    logic        m_axis_tlast;   // last

    crc16_packet_deframer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Stimulus and scoreboard storage
    logic [7:0]    rx_bytes_q[$];
    t_frame_result awaited_results[$];
    int            fail_count = 0;
    int            cycle_count = 0;
    int            tx_wait, tx_calm = 0;
    int            rx_wait, rx_calm = 0;

    // Model state of the deframer
    t_phase      hunt_phase;
    int          frame_len;
    int          body_pos;
    logic [15:0] frame_crc;
    logic [7:0]  held_id, held_instr, held_crc_hi;
    logic [7:0]  param_mem[MAX_PARAMS];

    // CRC-16, polynomial 0x8005, one input bit at a time, MSB first
    function automatic logic [15:0] crc16_add_byte(input logic [15:0] crc,
                                                   input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0};
            if (fb) crc = crc ^ CRC_POLY;
        end
        return crc;
    endfunction

    // Wait before the next beat: mostly 0..6, with stretches of none
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    task automatic push_result(input t_status st, input logic [7:0] id,
                               input logic [7:0] ins, input logic [7:0] prm,
                               input int idx, input logic has, input logic lst);
        t_frame_result r;
        r.status    = st;
        r.motor_id  = id;
        r.instr     = ins;
        r.param     = prm;
        r.index     = idx[5:0];
        r.has_param = has;
        r.last      = lst;
        awaited_results.push_back(r);
    endtask

    // Advance the deframer model by one accepted byte
    task automatic deframe_byte(input logic [7:0] b);
        logic [15:0] got_crc;
        int          nparams;
        case (hunt_phase)
            PH_SYNC1: begin
                if (b == SYNC_BYTE) hunt_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                hunt_phase = (b == SYNC_BYTE) ? PH_SYNC3 : PH_SYNC1;
            end
            PH_SYNC3: begin
                if (b == SYNC_LAST)      hunt_phase = PH_LEN;
                else if (b != SYNC_BYTE) hunt_phase = PH_SYNC1;
            end
            PH_LEN: begin
                frame_len  = b;
                hunt_phase = PH_ZERO;
            end
            PH_ZERO: begin
                if (b != ZERO_BYTE) begin
                    // broken header: this byte rejoins the hunt
                    hunt_phase = (b == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
                end else if (frame_len < MIN_LEN || frame_len > MAX_LEN) begin
                    hunt_phase = PH_SYNC1;
                    push_result(ST_BAD_LEN, 8'h00, 8'h00, 8'h00, 0, 1'b0, 1'b1);
                end else begin
                    frame_crc  = crc16_add_byte(CRC_INIT, SYNC_BYTE);
                    frame_crc  = crc16_add_byte(frame_crc, SYNC_BYTE);
                    frame_crc  = crc16_add_byte(frame_crc, SYNC_LAST);
                    frame_crc  = crc16_add_byte(frame_crc, 8'(frame_len));
                    frame_crc  = crc16_add_byte(frame_crc, ZERO_BYTE);
                    body_pos   = 0;
                    hunt_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (body_pos + 2 < frame_len) begin
                    frame_crc = crc16_add_byte(frame_crc, b);
                    if (body_pos == 0)      held_id = b;
                    else if (body_pos == 1) held_instr = b;
                    else                    param_mem[body_pos - 2] = b;
                    body_pos++;
                end else if (body_pos + 2 == frame_len) begin
                    held_crc_hi = b;
                    body_pos++;
                end else begin
                    // low CRC byte closes the packet
                    hunt_phase = PH_SYNC1;
                    body_pos   = 0;
                    got_crc    = {held_crc_hi, b};
                    nparams    = frame_len - 4;
                    if (got_crc != frame_crc) begin
                        push_result(ST_CRC_ERR, held_id, held_instr, 8'h00, 0, 1'b0, 1'b1);
                    end else if (nparams == 0) begin
                        push_result(ST_OK, held_id, held_instr, 8'h00, 0, 1'b0, 1'b1);
                    end else begin
                        for (int i = 0; i < nparams; i++) begin
                            push_result(ST_OK, held_id, held_instr, param_mem[i], i, 1'b1,
                                        (i == nparams - 1));
                        end
                    end
                end
            end
            default: hunt_phase = PH_SYNC1;
        endcase
    endtask

    // Queue one framed packet; an illegal length gets its header only.
    // A spoilt packet has one payload bit flipped.
    task automatic add_packet(input int len, input bit spoil,
                              input logic [7:0] id, input logic [7:0] ins);
        logic [7:0]  body[$];
        logic [15:0] crc;
        int          pick;
        rx_bytes_q.push_back(SYNC_BYTE);
        rx_bytes_q.push_back(SYNC_BYTE);
        rx_bytes_q.push_back(SYNC_LAST);
        rx_bytes_q.push_back(8'(len));
        rx_bytes_q.push_back(ZERO_BYTE);
        if (len < MIN_LEN || len > MAX_LEN) begin
            return;
        end
        body.push_back(id);
        body.push_back(ins);
        for (int i = 0; i < len - 4; i++) body.push_back(8'($urandom_range(0, 255)));
        crc = crc16_add_byte(CRC_INIT, SYNC_BYTE);
        crc = crc16_add_byte(crc, SYNC_BYTE);
        crc = crc16_add_byte(crc, SYNC_LAST);
        crc = crc16_add_byte(crc, 8'(len));
        crc = crc16_add_byte(crc, ZERO_BYTE);
        foreach (body[i]) crc = crc16_add_byte(crc, body[i]);
        body.push_back(crc[15:8]);
        body.push_back(crc[7:0]);
        if (spoil) begin
            pick       = $urandom_range(0, len - 1);
            body[pick] = body[pick] ^ (8'h01 << $urandom_range(0, 7));
        end
        foreach (body[i]) rx_bytes_q.push_back(body[i]);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Model reset state
    initial begin
        hunt_phase  = PH_SYNC1;
        frame_len   = 0;
        body_pos    = 0;
        frame_crc   = '0;
        held_id     = '0;
        held_instr  = '0;
        held_crc_hi = '0;
    end

    // Byte source: one wait drawn per beat
    always @(posedge i_clk) begin : byte_driver
        logic       nv;
        logic [7:0] nd;
        int         w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            tx_wait       <= 0;
        end else begin
            nv = s_axis_tvalid;
            nd = s_axis_tdata;
            w  = tx_wait;
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_byte(s_axis_tdata);
                w  = draw_wait(tx_calm);
                nv = 1'b0;
                if (w == 0 && rx_bytes_q.size() > 0) begin
                    nd = rx_bytes_q.pop_front();
                    nv = 1'b1;
                end
            end else if (!s_axis_tvalid) begin
                if (w > 1) begin
                    w--;
                end else if (rx_bytes_q.size() > 0) begin
                    w  = 0;
                    nd = rx_bytes_q.pop_front();
                    nv = 1'b1;
                end
            end
            s_axis_tvalid <= nv;
            s_axis_tdata  <= nd;
            tx_wait       <= w;
        end
    end

    // Result sink and scoreboard
    always @(posedge i_clk) begin : result_monitor
        t_frame_result got, want;
        int            w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            got.status    = t_status'(m_axis_tuser[1:0]);
            got.motor_id  = m_axis_tdata[7:0];
            got.instr     = m_axis_tdata[15:8];
            got.param     = m_axis_tdata[23:16];
            got.index     = m_axis_tdata[29:24];
            got.has_param = m_axis_tuser[2];
            got.last      = m_axis_tlast;
            if (awaited_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result beat: status=%0d id=%02h instr=%02h",
                             got.status, got.motor_id, got.instr,
                             " param=%02h index=%0d has=%0b last=%0b",
                             got.param, got.index, got.has_param, got.last);
            end else begin
                want = awaited_results.pop_front();
                if (got.status !== want.status || got.motor_id !== want.motor_id ||
                    got.instr !== want.instr || got.param !== want.param ||
                    got.index !== want.index || got.has_param !== want.has_param ||
                    got.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display(
                            "mismatch: exp st=%0d id=%02h ins=%02h prm=%02h ix=%0d h=%0b l=%0b",
                            want.status, want.motor_id, want.instr, want.param,
                            want.index, want.has_param, want.last,
                            " / got st=%0d id=%02h ins=%02h prm=%02h ix=%0d h=%0b l=%0b",
                            got.status, got.motor_id, got.instr, got.param,
                            got.index, got.has_param, got.last);
                end
            end
            w = draw_wait(rx_calm);
            m_axis_tready <= (w == 0);
            rx_wait       <= w;
        end else if (!m_axis_tready) begin
            if (rx_wait > 1) begin
                rx_wait <= rx_wait - 1;
            end else begin
                m_axis_tready <= 1'b1;
                rx_wait       <= 0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus build, reset and end of run
    initial begin : stimulus
        int kind, len, start_bytes;
        i_rst_n = 1'b0;

        // directed: shortest good packet with extreme id and instruction
        add_packet(4, 1'b0, 8'h00, 8'hFF);
        // lengths just outside the legal range
        add_packet(3, 1'b0, 8'h00, 8'h00);
        add_packet(MAX_PARAMS + 5, 1'b0, 8'h00, 8'h00);
        // extra FF before FD, then a sync byte where 00 belongs, then junk
        rx_bytes_q.push_back(SYNC_BYTE);
        rx_bytes_q.push_back(SYNC_BYTE);
        rx_bytes_q.push_back(SYNC_BYTE);
        rx_bytes_q.push_back(SYNC_LAST);
        rx_bytes_q.push_back(8'h06);
        rx_bytes_q.push_back(SYNC_BYTE);
        rx_bytes_q.push_back(8'h41);
        // header broken on its third byte
        rx_bytes_q.push_back(SYNC_BYTE);
        rx_bytes_q.push_back(SYNC_BYTE);
        rx_bytes_q.push_back(8'h12);

        // random: mostly well-formed short packets, some long, bad or noise
        start_bytes = rx_bytes_q.size();
        while (rx_bytes_q.size() - start_bytes < 75) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    rx_bytes_q.push_back(($urandom_range(0, 2) == 0) ? SYNC_BYTE
                                         : 8'($urandom_range(0, 255)));
                end
            end
            kind = $urandom_range(0, 19);
            if (kind < 12)       len = $urandom_range(4, 10);
            else if (kind < 14)  len = MAX_LEN;
            else if (kind < 16)  len = $urandom_range(11, MAX_LEN - 1);
            else if (kind == 16) len = $urandom_range(0, 3);
            else if (kind == 17) len = $urandom_range(MAX_LEN + 1, 255);
            else                 len = -1;
            if (len < 0) begin
                // truncated header, broken at a random point
                rx_bytes_q.push_back(SYNC_BYTE);
                if ($urandom_range(0, 1)) rx_bytes_q.push_back(SYNC_BYTE);
                if ($urandom_range(0, 1)) begin
                    rx_bytes_q.push_back(SYNC_LAST);
                    rx_bytes_q.push_back(8'($urandom_range(0, 255)));
                end
                rx_bytes_q.push_back(8'($urandom_range(1, 254)));
            end else begin
                add_packet(len, ($urandom_range(0, 6) == 0),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_bytes_q.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && awaited_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
